FILE: sv/ieval_pkg.sv
// Shared types and constants for the infix expression evaluator.
`timescale 1ns / 1ps

package ieval_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_OTHER = 3'd4
    } op_t;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int OUT_WIDTH = 32;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    typedef struct packed {
        logic done;
    } md_rsp_t;

endpackage

FILE: sv/ieval_muldiv.sv
// Iterative multiply / signed divide unit sharing one adder, one bit per cycle.
`timescale 1ns / 1ps

module ieval_muldiv #(
    parameter int W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ieval_pkg::md_req_t req,
    input  logic [W-1:0]      opa,
    input  logic [W-1:0]      opb,
    output ieval_pkg::md_rsp_t rsp,
    output logic [W-1:0]      result
);
    import ieval_pkg::*;

    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          fix_reg, fix_next;
    logic          done_reg, done_next;
    logic          div_reg, div_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [W-1:0]  sh_reg, sh_next;
    logic [W-1:0]  res_reg, res_next;

    logic [W:0] add_x, add_y, add_sum;

    // shared adder: multiply accumulates, divide trial-subtracts
    always_comb begin
        add_x   = div_reg ? {acc_reg, sh_reg[W-1]} : {1'b0, acc_reg};
        add_y   = {1'b0, dvs_reg};
        add_sum = add_x + (add_y ^ {(W+1){div_reg}}) + (W+1)'(div_reg);
    end

    always_comb begin
        busy_next = busy_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        div_next  = div_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        dvs_next  = dvs_reg;
        sh_next   = sh_reg;
        res_next  = res_reg;
        if (req.start) begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = CW'(W - 1);
            acc_next  = '0;
            if (req.is_div) begin
                neg_next = opa[W-1] ^ opb[W-1];
                sh_next  = opa[W-1] ? (~opa + W'(1)) : opa;
                dvs_next = opb[W-1] ? (~opb + W'(1)) : opb;
            end else begin
                neg_next = 1'b0;
                dvs_next = opa;
                sh_next  = opb;
            end
        end else if (busy_reg) begin
            if (div_reg) begin
                if (!add_sum[W]) begin
                    acc_next = add_sum[W-1:0];
                    sh_next  = {sh_reg[W-2:0], 1'b1};
                end else begin
                    acc_next = add_x[W-1:0];
                    sh_next  = {sh_reg[W-2:0], 1'b0};
                end
            end else begin
                if (sh_reg[0]) begin
                    acc_next = add_sum[W-1:0];
                end
                dvs_next = {dvs_reg[W-2:0], 1'b0};
                sh_next  = {1'b0, sh_reg[W-1:1]};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end else if (fix_reg) begin
            // sign correction of the quotient, or the product passed through for multiply
            if (div_reg) begin
                res_next = neg_reg ? (~sh_reg + W'(1)) : sh_reg;
            end else begin
                res_next = acc_reg;
            end
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
        end
        div_reg <= div_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        dvs_reg <= dvs_next;
        sh_reg  <= sh_next;
        res_reg <= res_next;
    end

    assign rsp.done = done_reg;
    assign result   = res_reg;

endmodule

FILE: sv/infix_expression_evaluator_core.sv
// Infix expression evaluator top level: character sequencer, term registers, result register.
// A digit or space is taken in ST_IDLE; a + - or other operator fold is done in ST_FOLD;
// a * or / fold runs the shared bit-serial multiply/divide unit from ST_FOLD and waits in ST_WAIT.
// End of text adds one more fold, then ST_OUT loads the result register once it is empty or being read.
// A new character is accepted only in ST_IDLE, so s_ready stays low while a fold or result load is pending.
// Reset (aresetn low, synchronous) clears all terms, the error flag and the result valid.
`timescale 1ns / 1ps

module infix_expression_evaluator_core #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_value,
    output logic        m_div_zero
);
    import ieval_pkg::*;

    localparam int W = DATA_WIDTH;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FOLD = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t       state_reg, state_next;
    op_t          pending_op_reg, pending_op_next;
    op_t          new_op_reg, new_op_next;
    logic         have_op_reg, have_op_next;
    logic         last_reg, last_next;
    logic [W-1:0] number_reg, number_next;
    logic [W-1:0] last_term_reg, last_term_next;
    logic [W-1:0] term_sum_reg, term_sum_next;
    logic         error_reg, error_next;
    logic         m_valid_reg, m_valid_next;
    logic [31:0]  m_value_reg, m_value_next;
    logic         m_div_zero_reg, m_div_zero_next;

    md_req_t      md_req;
    md_rsp_t      md_rsp;
    logic [W-1:0] md_result;
    logic         fold_done;
    logic [W-1:0] total;
    logic [31:0]  total_out;

    ieval_muldiv #(
        .W(W)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .opa     (last_term_reg),
        .opb     (number_reg),
        .rsp     (md_rsp),
        .result  (md_result)
    );

    assign total = term_sum_reg + last_term_reg;

    generate
        if (W >= OUT_WIDTH) begin : g_wide
            assign total_out = total[OUT_WIDTH-1:0];
        end else begin : g_narrow
            assign total_out = {{(OUT_WIDTH-W){1'b0}}, total};
        end
    endgenerate

    always_comb begin
        state_next      = state_reg;
        pending_op_next = pending_op_reg;
        new_op_next     = new_op_reg;
        have_op_next    = have_op_reg;
        last_next       = last_reg;
        number_next     = number_reg;
        last_term_next  = last_term_reg;
        term_sum_next   = term_sum_reg;
        error_next      = error_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_value_next    = m_value_reg;
        m_div_zero_next = m_div_zero_reg;
        md_req.start    = 1'b0;
        md_req.is_div   = 1'b0;
        fold_done       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    last_next    = s_end_of_text;
                    have_op_next = 1'b0;
                    state_next   = s_end_of_text ? ST_FOLD : ST_IDLE;
                    if (s_char_code >= CH_ZERO && s_char_code <= CH_NINE) begin
                        number_next = {number_reg[W-4:0], 3'b000}
                                    + {number_reg[W-2:0], 1'b0}
                                    + W'(s_char_code[3:0]);
                    end else if (s_char_code != CH_SPACE) begin
                        have_op_next = 1'b1;
                        state_next   = ST_FOLD;
                        case (s_char_code)
                            CH_PLUS:  new_op_next = OP_ADD;
                            CH_MINUS: new_op_next = OP_SUB;
                            CH_STAR:  new_op_next = OP_MUL;
                            CH_SLASH: new_op_next = OP_DIV;
                            default:  new_op_next = OP_OTHER;
                        endcase
                    end
                end
            end
            ST_FOLD: begin
                case (pending_op_reg)
                    OP_ADD: begin
                        term_sum_next  = total;
                        last_term_next = number_reg;
                        fold_done      = 1'b1;
                    end
                    OP_SUB: begin
                        term_sum_next  = total;
                        last_term_next = ~number_reg + W'(1);
                        fold_done      = 1'b1;
                    end
                    OP_MUL: begin
                        md_req.start = 1'b1;
                        state_next   = ST_WAIT;
                    end
                    OP_DIV: begin
                        if (number_reg == '0) begin
                            error_next     = 1'b1;
                            last_term_next = '0;
                            fold_done      = 1'b1;
                        end else begin
                            md_req.start  = 1'b1;
                            md_req.is_div = 1'b1;
                            state_next    = ST_WAIT;
                        end
                    end
                    default: begin
                        fold_done = 1'b1;
                    end
                endcase
            end
            ST_WAIT: begin
                if (md_rsp.done) begin
                    last_term_next = md_result;
                    fold_done      = 1'b1;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_value_next    = total_out;
                    m_div_zero_next = error_reg;
                    pending_op_next = OP_ADD;
                    number_next     = '0;
                    last_term_next  = '0;
                    term_sum_next   = '0;
                    error_next      = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (fold_done) begin
            number_next = '0;
            if (have_op_reg) begin
                pending_op_next = new_op_reg;
                have_op_next    = 1'b0;
                state_next      = last_reg ? ST_FOLD : ST_IDLE;
            end else begin
                state_next = ST_OUT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pending_op_reg <= OP_ADD;
            have_op_reg    <= 1'b0;
            last_reg       <= 1'b0;
            number_reg     <= '0;
            last_term_reg  <= '0;
            term_sum_reg   <= '0;
            error_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pending_op_reg <= pending_op_next;
            have_op_reg    <= have_op_next;
            last_reg       <= last_next;
            number_reg     <= number_next;
            last_term_reg  <= last_term_next;
            term_sum_reg   <= term_sum_next;
            error_reg      <= error_next;
            m_valid_reg    <= m_valid_next;
        end
        new_op_reg     <= new_op_next;
        m_value_reg    <= m_value_next;
        m_div_zero_reg <= m_div_zero_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_value    = m_value_reg;
    assign m_div_zero = m_div_zero_reg;

endmodule

FILE: tb/sv/infix_expression_evaluator_core_test.sv
// Self-checking testbench for the infix expression evaluator core.
`timescale 1ns / 1ps

module infix_expression_evaluator_core_test;
    import ieval_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       eot;
        logic       drain;
    } char_req_t;

    typedef struct packed {
        logic [31:0] value;
        logic        div_zero;
    } expr_result_t;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_char_code = '0;
    logic               s_end_of_text = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_value;
    logic               m_div_zero;

    char_req_t    char_stream[$];
    expr_result_t due_results[$];
    logic [7:0]   expr_buf[$];
    logic         hold_next = 1'b0;
    int           n_items = 0;
    int           err_cnt = 0;

    // running evaluation state
    op_t         ev_op;
    logic [31:0] ev_num;
    logic [31:0] ev_last;
    logic [31:0] ev_sum;
    logic        ev_err;

    int          gap_left;
    int          burst_left;
    logic [15:0] stall_pat;
    logic        free_run;
    int          mon_cyc;

    infix_expression_evaluator_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_div_zero    (m_div_zero)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic logic [31:0] quot_trunc(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    task automatic clear_eval();
        ev_op   = OP_ADD;
        ev_num  = '0;
        ev_last = '0;
        ev_sum  = '0;
        ev_err  = 1'b0;
    endtask

    task automatic fold_term();
        case (ev_op)
            OP_ADD: begin
                ev_sum  = ev_sum + ev_last;
                ev_last = ev_num;
            end
            OP_SUB: begin
                ev_sum  = ev_sum + ev_last;
                ev_last = -ev_num;
            end
            OP_MUL: begin
                ev_last = ev_last * ev_num;
            end
            OP_DIV: begin
                if (ev_num == '0) begin
                    ev_err  = 1'b1;
                    ev_last = '0;
                end else begin
                    ev_last = quot_trunc(ev_last, ev_num);
                end
            end
            default: ;
        endcase
        ev_num = '0;
    endtask

    task automatic eval_char(input logic [7:0] c, input logic eot);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            ev_num = ev_num * 32'd10 + 32'(c - CH_ZERO);
        end else if (c != CH_SPACE) begin
            fold_term();
            case (c)
                CH_PLUS:  ev_op = OP_ADD;
                CH_MINUS: ev_op = OP_SUB;
                CH_STAR:  ev_op = OP_MUL;
                CH_SLASH: ev_op = OP_DIV;
                default:  ev_op = OP_OTHER;
            endcase
        end
        if (eot) begin
            fold_term();
            due_results.push_back('{value: ev_sum + ev_last, div_zero: ev_err});
            clear_eval();
        end
    endtask

    task automatic put_byte(input logic [7:0] c);
        expr_buf.push_back(c);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) expr_buf.push_back(s[i]);
    endtask

    task automatic commit_expr();
        int n;
        n = expr_buf.size();
        for (int i = 0; i < n; i++) begin
            char_stream.push_back('{code: expr_buf[i], eot: (i == n - 1),
                                    drain: (hold_next && i == 0)});
        end
        n_items += n;
        expr_buf.delete();
        hold_next = 1'b0;
    endtask

    task automatic put_op();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) put_byte(8'($urandom_range(0, 255)));
        else if (r < 6) put_byte(CH_PLUS);
        else if (r < 11) put_byte(CH_MINUS);
        else if (r < 16) put_byte(CH_STAR);
        else put_byte(CH_SLASH);
    endtask

    task automatic put_spaces();
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) put_byte(CH_SPACE);
    endtask

    task automatic put_number();
        int r;
        int n;
        r = $urandom_range(0, 39);
        if (r == 0) put_text("2147483648");
        else if (r == 1) put_text("4294967295");
        else if (r < 6) put_text("0");
        else begin
            n = (r < 10) ? $urandom_range(9, 12) : $urandom_range(1, 3);
            repeat (n) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic queue_random_expr();
        int terms;
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
        end else begin
            terms = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0) put_op();
            for (int i = 0; i < terms; i++) begin
                if (i > 0) put_op();
                put_spaces();
                put_number();
                put_spaces();
            end
            if ($urandom_range(0, 9) == 0) put_op();
        end
        commit_expr();
    endtask

    // request driver
    always @(posedge aclk) begin : drive_p
        char_req_t nxt;
        if (!aresetn) begin
            s_valid       <= 1'b0;
            s_char_code   <= '0;
            s_end_of_text <= 1'b0;
            clear_eval();
            gap_left   = 0;
            burst_left = 0;
        end else begin
            if (s_valid && s_ready) eval_char(s_char_code, s_end_of_text);
            if (s_valid && !s_ready) begin
                // hold until taken
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (char_stream.size() > 0 &&
                         (!char_stream[0].drain || due_results.size() == 0)) begin
                nxt = char_stream.pop_front();
                s_valid       <= 1'b1;
                s_char_code   <= nxt.code;
                s_end_of_text <= nxt.eot;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 20);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                        8:          gap_left = $urandom_range(5, 40);
                        default:    gap_left = $urandom_range(40, 90);
                    endcase
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : watch_p
        expr_result_t want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            stall_pat = 16'hA5C3;
            free_run  = 1'b0;
            mon_cyc   = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %0d div_zero %0b",
                             $time, m_value, m_div_zero);
                    err_cnt++;
                end else begin
                    want = due_results.pop_front();
                    if (m_value !== want.value) begin
                        $display("%0t: value: expected %0d, actual %0d",
                                 $time, $signed(want.value), m_value);
                        err_cnt++;
                    end
                    if (m_div_zero !== want.div_zero) begin
                        $display("%0t: div_zero: expected %0b, actual %0b",
                                 $time, want.div_zero, m_div_zero);
                        err_cnt++;
                    end
                end
            end
            mon_cyc++;
            if (mon_cyc % 97 == 0) begin
                stall_pat = 16'($urandom);
                free_run  = ($urandom_range(0, 2) == 0);
            end
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            m_ready <= free_run | stall_pat[0];
        end
    end

    initial begin
        int n_expr;
        // leading multiply, trailing divide
        put_text("*3/");
        commit_expr();
        // divide by zero mid-expression, ends on a space
        put_text("8/0+9 ");
        commit_expr();
        put_text("-7/2");
        commit_expr();
        // unknown operators, including top-bit bytes
        put_text("5#3");
        put_byte(8'hFF);
        put_byte(8'h80);
        put_text("1");
        commit_expr();
        // most negative over minus one, via wrapped literals
        put_text("2147483648/4294967295");
        commit_expr();

        n_expr = 0;
        while (n_items < 1050) begin
            if (n_expr % 40 == 0) hold_next = 1'b1;
            queue_random_expr();
            n_expr++;
        end

        wait (aresetn);
        while (char_stream.size() > 0 || s_valid) @(posedge aclk);
        while (due_results.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
sv/ieval_pkg.sv
sv/ieval_muldiv.sv
sv/infix_expression_evaluator_core.sv
tb/sv/infix_expression_evaluator_core_test.sv
